@@ rtl/core/mcq_pkg.sv @@
// shared constants, types and helpers of the median cut color quantizer
// no dependencies
`timescale 1ns / 1ps

package mcq_pkg;

  localparam int NPIX   = 4096;
  localparam int PIX_AW = 12;
  localparam int CNT_W  = 13;
  localparam int NBOX   = 256;
  localparam int BOX_AW = 8;
  localparam int BOXN_W = 9;
  localparam int SUM_W  = 20;
  localparam int PTR_W  = 14;

  localparam logic [BOXN_W-1:0] PAL_MIN = BOXN_W'(2);
  localparam logic [BOXN_W-1:0] PAL_MAX = BOXN_W'(NBOX);

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // color in the upper bits, original position in the lower bits
  typedef logic [31+PIX_AW:0] pix_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] lo_idx;
    logic [CNT_W-1:0] hi_idx;
  } box_t;

  function automatic logic [7:0] chan(input logic [31:0] color, input logic [1:0] k);
    logic [7:0] v;
    unique case (k)
      2'd0: v = color[31:24];
      2'd1: v = color[23:16];
      2'd2: v = color[15:8];
      default: v = color[7:0];
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/mcq_if.sv @@
// valid/ready channel interfaces for pixel items and result items
// depends on nothing
`timescale 1ns / 1ps

interface mcq_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;
  logic        last_pixel;
  logic [11:0] read_index;

  modport source (output valid, kind, red_in, green_in, blue_in, alpha_in, last_pixel,
                  read_index, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, alpha_in, last_pixel,
                read_index, output ready);
endinterface

interface mcq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic [8:0] colors_used;
  logic [1:0] status;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, colors_used, status,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, colors_used, status,
                output ready);
endinterface

@@ rtl/core/median_cut_color_quantizer.sv @@
// median cut color quantizer: pixel, scratch, result and box memories with a sequencer
// a push not marked last gives its result in the next cycle, one push per cycle while results
// are taken; a read beat waits in S_RDW; the push marked last runs quantization: per split a
// box search, axis scan, merge passes and copy-back, then per box a sum, 4 divides, write-back
// synchronous reset clears counts, the done flag and the color limit (to 256); memories keep data
// depends on mcq_pkg, mcq_if, mcq_div
`timescale 1ns / 1ps

module median_cut_color_quantizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [8:0]                 cfg_wr_data,
  mcq_in_if.sink                     pix,
  mcq_out_if.source                  res
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDW  = 5'd1;
  localparam logic [4:0] S_INIT = 5'd2;
  localparam logic [4:0] S_CHK  = 5'd3;
  localparam logic [4:0] S_SELR = 5'd4;
  localparam logic [4:0] S_SELC = 5'd5;
  localparam logic [4:0] S_AX   = 5'd6;
  localparam logic [4:0] S_AXF  = 5'd7;
  localparam logic [4:0] S_MSEG = 5'd8;
  localparam logic [4:0] S_MRD  = 5'd9;
  localparam logic [4:0] S_MCMP = 5'd10;
  localparam logic [4:0] S_CP   = 5'd11;
  localparam logic [4:0] S_SPL1 = 5'd12;
  localparam logic [4:0] S_SPL2 = 5'd13;
  localparam logic [4:0] S_MNR  = 5'd14;
  localparam logic [4:0] S_MNB  = 5'd15;
  localparam logic [4:0] S_MNS  = 5'd16;
  localparam logic [4:0] S_DVS  = 5'd17;
  localparam logic [4:0] S_DVW  = 5'd18;
  localparam logic [4:0] S_MNW  = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  localparam int AW = mcq_pkg::PIX_AW;
  localparam int CW = mcq_pkg::CNT_W;
  localparam int PW = mcq_pkg::PTR_W;
  localparam int NW = mcq_pkg::BOXN_W;

  logic [4:0]    state;
  logic [NW-1:0] color_limit;
  logic [NW-1:0] want;
  logic [CW-1:0] pixel_count;
  logic [NW-1:0] box_count;
  logic          quantized_done;
  logic [1:0]    push_status;

  // memories
  mcq_pkg::pix_word_t ps_mem [mcq_pkg::NPIX];
  mcq_pkg::pix_word_t sc_mem [mcq_pkg::NPIX];
  logic [31:0]        rs_mem [mcq_pkg::NPIX];
  mcq_pkg::box_t      box_mem [mcq_pkg::NBOX];

  mcq_pkg::pix_word_t ps_qa, ps_qb, ps_wd, sc_q, sc_wd;
  logic [AW-1:0]      psa, psb, ps_wa, sc_wa, sc_ra, rs_wa;
  logic               ps_we, sc_we, rs_we, box_we;
  logic [31:0]        rs_q, rs_wd;
  mcq_pkg::box_t      box_q, box_wd;
  logic [mcq_pkg::BOX_AW-1:0] box_wa, box_ra;

  // sequencer registers
  logic [NW-1:0]   i;
  logic [NW-1:0]   target;
  logic [CW-1:0]   best;
  logic            found;
  logic [CW-1:0]   tb, te;
  logic [CW-1:0]   sp, sp_d;
  logic            rv;
  logic [7:0]      lo [4];
  logic [7:0]      hi [4];
  logic [1:0]      axis;
  logic [PW-1:0]   w, s, m, f, x, y, o;
  logic [mcq_pkg::SUM_W-1:0] sum [4];
  logic [7:0]      mean_ch [4];
  logic [1:0]      ch;

  // output register
  logic          o_valid;
  logic [31:0]   o_color;
  logic [NW-1:0] o_colors;
  logic [1:0]    o_status;

  logic          in_fire;
  logic [CW-1:0] pc_eff;
  logic          full;
  logic [31:0]   in_color;
  logic [CW-1:0] n;
  logic [CW-1:0] mid;
  logic          scan_go;
  logic [51:0]   ka, kb;
  logic          take_y;
  logic [CW-1:0] cnt_q;
  logic [7:0]    rng [4];
  logic [1:0]    ax_pick;
  logic          div_start, div_done;
  logic [mcq_pkg::SUM_W-1:0] div_q;

  assign pix.ready = (state == S_IDLE) && (!o_valid || res.ready);
  assign in_fire   = pix.valid && pix.ready;
  assign pc_eff    = quantized_done ? '0 : pixel_count;
  assign full      = (pc_eff == CW'(mcq_pkg::NPIX));
  assign in_color  = {pix.red_in, pix.green_in, pix.blue_in, pix.alpha_in};
  assign n         = te - tb;
  assign mid       = tb + (n >> 1);
  assign scan_go   = (sp < te);
  assign cnt_q     = box_q.hi_idx - box_q.lo_idx;

  assign ka = {mcq_pkg::chan(ps_qa[43:12], axis), ps_qa};
  assign kb = {mcq_pkg::chan(ps_qb[43:12], axis), ps_qb};
  assign take_y = (x >= m) || ((y < f) && (kb < ka));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rng[k] = hi[k] - lo[k];
    end
    ax_pick = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (rng[k] > rng[ax_pick]) begin
        ax_pick = 2'(k);
      end
    end
  end

  always_comb begin
    ps_we  = 1'b0;
    ps_wa  = pc_eff[AW-1:0];
    ps_wd  = {in_color, pc_eff[AW-1:0]};
    psa    = sp[AW-1:0];
    psb    = y[AW-1:0];
    if (in_fire && pix.kind == mcq_pkg::KIND_PUSH && !full) begin
      ps_we = 1'b1;
    end
    if (state == S_CP && rv) begin
      ps_we = 1'b1;
      ps_wa = sp_d[AW-1:0];
      ps_wd = sc_q;
    end
    if (state == S_MRD) begin
      psa = x[AW-1:0];
    end
    sc_we  = (state == S_MCMP);
    sc_wa  = o[AW-1:0];
    sc_wd  = take_y ? ps_qb : ps_qa;
    sc_ra  = sp[AW-1:0];
    rs_we  = (state == S_MNW) && rv;
    rs_wa  = ps_qa[AW-1:0];
    rs_wd  = {mean_ch[0], mean_ch[1], mean_ch[2], mean_ch[3]};
    box_ra = i[mcq_pkg::BOX_AW-1:0];
    box_we = 1'b0;
    box_wa = '0;
    box_wd = '{lo_idx: '0, hi_idx: pixel_count};
    unique case (state)
      S_INIT: box_we = 1'b1;
      S_SPL1: begin
        box_we = 1'b1;
        box_wa = target[mcq_pkg::BOX_AW-1:0];
        box_wd = '{lo_idx: tb, hi_idx: mid};
      end
      S_SPL2: begin
        box_we = 1'b1;
        box_wa = box_count[mcq_pkg::BOX_AW-1:0];
        box_wd = '{lo_idx: mid, hi_idx: te};
      end
      default: box_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ps_we) ps_mem[ps_wa] <= ps_wd;
    ps_qa <= ps_mem[psa];
    ps_qb <= ps_mem[psb];
  end

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[sc_wa] <= sc_wd;
    sc_q <= sc_mem[sc_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_q <= rs_mem[pix.read_index];
  end

  always_ff @(posedge clk) begin
    if (box_we) box_mem[box_wa] <= box_wd;
    box_q <= box_mem[box_ra];
  end

  assign div_start = (state == S_DVS);

  mcq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum[ch]),
    .divisor  (n),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      color_limit    <= mcq_pkg::PAL_MAX;
      pixel_count    <= '0;
      box_count      <= '0;
      quantized_done <= 1'b0;
      o_valid        <= 1'b0;
      rv             <= 1'b0;
    end else begin
      if (cfg_wr_en) color_limit <= cfg_wr_data;
      if (o_valid && res.ready) o_valid <= 1'b0;

      // shared pipelined scan over [sp, te)
      if (state == S_AX || state == S_CP || state == S_MNS || state == S_MNW) begin
        rv <= scan_go;
        if (scan_go) begin
          sp   <= sp + CW'(1);
          sp_d <= sp;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (pix.kind == mcq_pkg::KIND_PUSH) begin
              if (quantized_done) begin
                box_count      <= '0;
                quantized_done <= 1'b0;
              end
              pixel_count <= full ? pc_eff : pc_eff + CW'(1);
              push_status <= full ? mcq_pkg::ST_FULL : mcq_pkg::ST_OK;
              if (pix.last_pixel) begin
                state <= S_INIT;
              end else begin
                o_valid  <= 1'b1;
                o_color  <= '0;
                o_colors <= '0;
                o_status <= full ? mcq_pkg::ST_FULL : mcq_pkg::ST_OK;
              end
            end else if (quantized_done && {1'b0, pix.read_index} < pixel_count) begin
              state <= S_RDW;
            end else begin
              o_valid  <= 1'b1;
              o_color  <= '0;
              o_colors <= quantized_done ? box_count : '0;
              o_status <= mcq_pkg::ST_BAD;
            end
          end
        end
        S_RDW: begin
          o_valid  <= 1'b1;
          o_color  <= rs_q;
          o_colors <= box_count;
          o_status <= mcq_pkg::ST_OK;
          state    <= S_IDLE;
        end
        S_INIT: begin
          box_count <= NW'(1);
          if (color_limit < mcq_pkg::PAL_MIN) want <= mcq_pkg::PAL_MIN;
          else if (color_limit > mcq_pkg::PAL_MAX) want <= mcq_pkg::PAL_MAX;
          else want <= color_limit;
          state <= S_CHK;
        end
        S_CHK: begin
          i     <= '0;
          best  <= CW'(1);
          found <= 1'b0;
          state <= (box_count >= want) ? S_MNR : S_SELR;
        end
        S_SELR: state <= S_SELC;
        S_SELC: begin
          if (cnt_q > best) begin
            best   <= cnt_q;
            target <= i;
            found  <= 1'b1;
            tb     <= box_q.lo_idx;
            te     <= box_q.hi_idx;
          end
          i <= i + NW'(1);
          if (i + NW'(1) == box_count) begin
            if (found || cnt_q > best) begin
              state <= S_AX;
              sp    <= (cnt_q > best) ? box_q.lo_idx : tb;
              rv    <= 1'b0;
              for (int k = 0; k < 4; k++) begin
                lo[k] <= 8'hff;
                hi[k] <= 8'h00;
              end
            end else begin
              i     <= '0;
              state <= S_MNR;
            end
          end else begin
            state <= S_SELR;
          end
        end
        S_AX: begin
          if (rv) begin
            for (int k = 0; k < 4; k++) begin
              if (mcq_pkg::chan(ps_qa[43:12], 2'(k)) < lo[k])
                lo[k] <= mcq_pkg::chan(ps_qa[43:12], 2'(k));
              if (mcq_pkg::chan(ps_qa[43:12], 2'(k)) > hi[k])
                hi[k] <= mcq_pkg::chan(ps_qa[43:12], 2'(k));
            end
          end
          if (!scan_go && !rv) state <= S_AXF;
        end
        S_AXF: begin
          axis  <= ax_pick;
          w     <= PW'(1);
          s     <= PW'(tb);
          state <= S_MSEG;
        end
        S_MSEG: begin
          if (s >= PW'(te)) begin
            sp    <= tb;
            rv    <= 1'b0;
            state <= S_CP;
          end else begin
            m     <= (s + w < PW'(te)) ? s + w : PW'(te);
            f     <= (s + (w << 1) < PW'(te)) ? s + (w << 1) : PW'(te);
            x     <= s;
            y     <= (s + w < PW'(te)) ? s + w : PW'(te);
            o     <= s;
            state <= S_MRD;
          end
        end
        S_MRD: begin
          if (x >= m && y >= f) begin
            s     <= f;
            state <= S_MSEG;
          end else begin
            state <= S_MCMP;
          end
        end
        S_MCMP: begin
          if (take_y) y <= y + PW'(1);
          else x <= x + PW'(1);
          o     <= o + PW'(1);
          state <= S_MRD;
        end
        S_CP: begin
          if (!scan_go && !rv) begin
            w <= w << 1;
            if ((w << 1) >= PW'(n)) begin
              state <= S_SPL1;
            end else begin
              s     <= PW'(tb);
              state <= S_MSEG;
            end
          end
        end
        S_SPL1: state <= S_SPL2;
        S_SPL2: begin
          box_count <= box_count + NW'(1);
          state     <= S_CHK;
        end
        S_MNR: begin
          state <= (i == box_count) ? S_FIN : S_MNB;
        end
        S_MNB: begin
          tb <= box_q.lo_idx;
          te <= box_q.hi_idx;
          sp <= box_q.lo_idx;
          rv <= 1'b0;
          for (int k = 0; k < 4; k++) sum[k] <= '0;
          if (cnt_q == '0) begin
            i     <= i + NW'(1);
            state <= S_MNR;
          end else begin
            state <= S_MNS;
          end
        end
        S_MNS: begin
          if (rv) begin
            for (int k = 0; k < 4; k++) begin
              sum[k] <= sum[k] + mcq_pkg::SUM_W'(mcq_pkg::chan(ps_qa[43:12], 2'(k)));
            end
          end
          if (!scan_go && !rv) begin
            ch    <= 2'd0;
            state <= S_DVS;
          end
        end
        S_DVS: state <= S_DVW;
        S_DVW: begin
          if (div_done) begin
            mean_ch[ch] <= div_q[7:0];
            if (ch == 2'd3) begin
              sp    <= tb;
              rv    <= 1'b0;
              state <= S_MNW;
            end else begin
              ch    <= ch + 2'd1;
              state <= S_DVS;
            end
          end
        end
        S_MNW: begin
          if (!scan_go && !rv) begin
            i     <= i + NW'(1);
            state <= S_MNR;
          end
        end
        S_FIN: begin
          quantized_done <= 1'b1;
          o_valid        <= 1'b1;
          o_color        <= '0;
          o_colors       <= box_count;
          o_status       <= push_status;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid       = o_valid;
  assign res.red_out     = o_color[31:24];
  assign res.green_out   = o_color[23:16];
  assign res.blue_out    = o_color[15:8];
  assign res.alpha_out   = o_color[7:0];
  assign res.colors_used = o_colors;
  assign res.status      = o_status;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !pix.ready)
    else $error("item accepted while quantizing");

  a_done_has_boxes: assert property (@(posedge clk) disable iff (rst)
    quantized_done |-> (box_count != '0 && pixel_count != '0))
    else $error("done without boxes");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= CW'(mcq_pkg::NPIX))
    else $error("pixel count overflow");

  a_merge_in_box: assert property (@(posedge clk) disable iff (rst)
    (state == S_MCMP) |-> (o >= PW'(tb) && o < PW'(te)))
    else $error("merge write outside box");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> (o_valid && quantized_done))
    else $error("quantization ended without result");

endmodule

@@ rtl/core/mcq_div.sv @@
// restoring divider, one quotient bit per cycle, for the box mean
// depends on mcq_pkg
`timescale 1ns / 1ps

module mcq_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mcq_pkg::SUM_W-1:0] dividend,
  input  logic [mcq_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [mcq_pkg::SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(mcq_pkg::SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mcq_pkg::SUM_W - 1);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [mcq_pkg::CNT_W:0]   rem;
  logic [mcq_pkg::CNT_W-1:0] dvs;
  logic [mcq_pkg::CNT_W:0]   rem_sh;

  assign rem_sh = {rem[mcq_pkg::CNT_W-1:0], quotient[mcq_pkg::SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem      <= rem_sh - {1'b0, dvs};
          quotient <= {quotient[mcq_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem      <= rem_sh;
          quotient <= {quotient[mcq_pkg::SUM_W-2:0], 1'b0};
        end
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
